### sv/adsr_pkg.sv
// adsr_pkg: shared types and codes for the adsr envelope generator
// stage codes, config register indexes and the divider status bundle
// no dependencies
`timescale 1ns / 1ps

package adsr_pkg;

  // envelope stage, as seen on the stage output
  typedef enum logic [2:0] {
    STG_STOPPED = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_e;

  // config register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_RELEASE = 2'd2;
  localparam logic [1:0] CFG_SUSTAIN = 2'd3;

  // sustain register width and full-scale value
  localparam int unsigned SusW = 17;
  localparam logic [SusW-1:0] SUS_ONE = 17'd65536;

  // status from the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### sv/adsr_div.sv
// adsr_div: restoring divider returning ceil(span / len), one quotient bit a cycle
// len of zero returns span; uses adsr_pkg for the status bundle
`timescale 1ns / 1ps

module adsr_div
  import adsr_pkg::*;
#(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] span_i,
  input  logic [DW-1:0] len_i,
  output logic [NW-1:0] result_o,
  output div_status_t   status_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_e;

  dstate_e       state_q;
  logic [NW-1:0] num_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] len_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] result_q;
  logic          done_q;
  logic          done_d;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          fits;

  // shift in the next numerator bit and try the subtract
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, len_q};
  assign fits  = ~diff[DW+1];

  // done pulses straight from idle for a zero length, otherwise after the fix-up state
  assign done_d = ((state_q == D_IDLE) & start_i & (len_i == '0)) | (state_q == D_FIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            if (len_i == '0) begin
              result_q <= span_i;
            end else begin
              num_q   <= span_i;
              len_q   <= len_i;
              rem_q   <= '0;
              quo_q   <= '0;
              cnt_q   <= CW'(NW);
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          num_q <= num_q << 1;
          quo_q <= {quo_q[NW-2:0], fits};
          rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          // round up when anything is left over
          result_q <= quo_q + NW'(rem_q != '0);
          state_q  <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign result_o      = result_q;
  assign status_o.busy = (state_q != D_IDLE);
  assign status_o.done = done_q;

endmodule

### sv/adsr_envelope_generator.sv
// adsr_envelope_generator: linear adsr envelope, one gate request in, one level request out
// a plain tick passes the step and out states; each segment step worked out by the shared
//   divider (at most two per tick) adds a full divide before the result goes out
// one tick at a time: gate requests stall until the last result is loaded for output;
//   a zero length skips the divider's bit loop
// reset: envelope stopped at level zero, lengths zero, sustain at full scale
`timescale 1ns / 1ps

module adsr_envelope_generator
  import adsr_pkg::*;
#(
  parameter int unsigned LEVEL_FRAC_BITS = 24,
  parameter int unsigned TIME_BITS       = 24,
  // config data is as wide as the widest register
  parameter int unsigned CFG_DW = (TIME_BITS > 17) ? TIME_BITS : 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  // gate requests
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              gate_i,
  // level requests
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [16:0]       level_o,
  output logic [2:0]        stage_o
);

  // level word holds 1.0 exactly, so one bit above the fraction
  localparam int unsigned F  = LEVEL_FRAC_BITS;
  localparam int unsigned L  = F + 1;
  localparam int unsigned T  = TIME_BITS;
  localparam logic [L-1:0] ONE_LEVEL = L'(1) << F;

  // sequencer: idle waits for a tick, div waits on the divider,
  // step applies one ramp step, out hands the result over
  typedef enum logic [1:0] {T_IDLE, T_DIV, T_STEP, T_OUT} tstate_e;

  // config registers
  logic [T-1:0]    attack_q;
  logic [T-1:0]    decay_q;
  logic [T-1:0]    release_q;
  logic [SusW-1:0] sustain_q;

  // envelope state
  tstate_e      state_q;
  stage_e       stage_q;
  logic [L-1:0] level_q;
  logic [L-1:0] step_q;
  logic         prev_gate_q;
  logic         div_to_step_q;  // after the divide, take a ramp step

  // divider request registers
  logic         div_start_q;
  logic         div_start_d;
  logic [L-1:0] div_span_q;
  logic [T-1:0] div_len_q;
  logic [L-1:0] div_result;
  div_status_t  div_status;

  // output register
  logic         out_valid_q;
  logic [16:0]  out_level_q;
  stage_e       out_stage_q;
  logic         out_load;

  // sustain clamped to 1.0 and scaled to the level format
  logic [SusW-1:0] sus_clamp;
  logic [L-1:0]    sus_fixed;

  // ramp arithmetic
  logic [L:0]   att_sum;
  logic         att_top;
  logic [L:0]   dec_diff;    // level minus sustain, top bit is the borrow
  logic         dec_done;
  logic         rel_done;
  logic         accept;
  logic         rise;
  logic         fall;

  assign sus_clamp = (sustain_q > SUS_ONE) ? SUS_ONE : sustain_q;
  assign sus_fixed = L'(sus_clamp) << (F - 16);

  assign att_sum  = {1'b0, level_q} + {1'b0, step_q};
  assign att_top  = (att_sum >= {1'b0, ONE_LEVEL});
  assign dec_diff = {1'b0, level_q} - {1'b0, sus_fixed};
  // at or below sustain, or within one step of it
  assign dec_done = dec_diff[L] | (dec_diff[L-1:0] <= step_q);
  assign rel_done = (level_q <= step_q);

  assign accept = in_valid_i & ~in_stall_o;
  assign rise   = gate_i & ~prev_gate_q & (stage_q == STG_STOPPED);
  assign fall   = ~gate_i & prev_gate_q & (stage_q != STG_STOPPED);

  assign in_stall_o = (state_q != T_IDLE);

  // a divide starts on a gate edge, and when attack reaches the top
  assign div_start_d = ((state_q == T_IDLE) & accept & (rise | fall))
                     | ((state_q == T_STEP) & (stage_q == STG_ATTACK) & att_top);

  // result goes out once the output register is free
  assign out_load = (state_q == T_OUT) & (~out_valid_q | ~out_stall_i);

  adsr_div #(
    .NW (L),
    .DW (T)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start_q),
    .span_i   (div_span_q),
    .len_i    (div_len_q),
    .result_o (div_result),
    .status_o (div_status)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      release_q <= '0;
      sustain_q <= SUS_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i[T-1:0];
        CFG_DECAY:   decay_q   <= cfg_data_i[T-1:0];
        CFG_RELEASE: release_q <= cfg_data_i[T-1:0];
        CFG_SUSTAIN: sustain_q <= cfg_data_i[SusW-1:0];
        default: ;
      endcase
    end
  end

  // divider start pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start_d;
    end
  end

  // sequencer and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      stage_q       <= STG_STOPPED;
      level_q       <= '0;
      step_q        <= '0;
      prev_gate_q   <= 1'b0;
      div_to_step_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            prev_gate_q <= gate_i;
            priority if (rise) begin
              // start attack from zero
              stage_q       <= STG_ATTACK;
              level_q       <= '0;
              div_span_q    <= ONE_LEVEL;
              div_len_q     <= attack_q;
              div_to_step_q <= 1'b1;
              state_q       <= T_DIV;
            end else if (fall) begin
              // release from wherever the level is now
              stage_q       <= STG_RELEASE;
              div_span_q    <= level_q;
              div_len_q     <= release_q;
              div_to_step_q <= 1'b1;
              state_q       <= T_DIV;
            end else begin
              state_q <= T_STEP;
            end
          end
        end

        T_DIV: begin
          if (div_status.done) begin
            step_q  <= div_result;
            state_q <= div_to_step_q ? T_STEP : T_OUT;
          end
        end

        T_STEP: begin
          state_q <= ((stage_q == STG_ATTACK) && att_top) ? T_DIV : T_OUT;
          unique case (stage_q)
            STG_ATTACK: begin
              if (att_top) begin
                // top reached, work out the decay step
                level_q       <= ONE_LEVEL;
                stage_q       <= STG_DECAY;
                div_span_q    <= ONE_LEVEL - sus_fixed;
                div_len_q     <= decay_q;
                div_to_step_q <= 1'b0;
              end else begin
                level_q <= att_sum[L-1:0];
              end
            end
            STG_DECAY: begin
              if (dec_done) begin
                level_q <= sus_fixed;
                stage_q <= STG_SUSTAIN;
              end else begin
                level_q <= level_q - step_q;
              end
            end
            STG_RELEASE: begin
              if (rel_done) begin
                level_q <= '0;
                stage_q <= STG_STOPPED;
              end else begin
                level_q <= level_q - step_q;
              end
            end
            STG_SUSTAIN, STG_STOPPED: ;
            default: begin
              level_q <= '0;
              stage_q <= STG_STOPPED;
            end
          endcase
        end

        T_OUT: begin
          // hand over once the output register is free
          if (out_load) begin
            out_level_q <= level_q[F -: 17];
            out_stage_q <= stage_q;
            state_q     <= T_IDLE;
          end
        end

        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign stage_o     = out_stage_q;

endmodule
